// ===== rtl/fss_pkg.sv =====
// Shared types, constants and the FNV prime multiply for the FNV-1a stream hash block.
package fss_pkg;

  localparam int unsigned HashWidth = 64;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned SigWidth  = 15;

  localparam logic [63:0] FnvOffsetBasis = 64'hCBF2_9CE4_8422_2325;

  // Signal scaling: (low32 mod 20001) - 10000
  localparam logic [14:0] SigModulus = 15'd20001;
  localparam logic [14:0] SigCenter  = 15'd10000;

  // Reciprocal for the modulo: q = (low32 * SigRecip) >> SigShift is exact or one short
  localparam int unsigned SigShift = 46;
  localparam logic [63:0] SigRecipWide = (64'd1 << SigShift) / 64'd20001;
  localparam logic [31:0] SigRecip = SigRecipWide[31:0];
  localparam int unsigned QuotWidth = 64 - SigShift;

  // Finished hash travelling from the hash core to the signal stage
  typedef struct packed {
    logic        valid;
    logic [63:0] hash;
  } fss_hash_word_t;

  // x * 0x00000100000001B3 mod 2^64; prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
  function automatic logic [63:0] fnv_prime_mult(input logic [63:0] x);
    logic [63:0] acc;
    acc = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    return acc;
  endfunction

endpackage

// ===== rtl/fss_hash_core.sv =====
// Running FNV-1a hash register and the finished-hash hold stage.
module fss_hash_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   word_valid,
  output logic                   word_ready,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output fss_pkg::fss_hash_word_t fin,
  input  logic                   fin_ready
);
  import fss_pkg::*;

  logic [63:0] running_hash;
  logic [63:0] hash_next;
  logic        take;
  logic        fin_valid;
  logic [63:0] fin_hash;

  assign fin        = '{valid: fin_valid, hash: fin_hash};
  assign word_ready = !fin_valid || fin_ready;
  assign take       = word_valid && word_ready;
  assign hash_next  = fnv_prime_mult(running_hash ^ {56'd0, data_byte});

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FnvOffsetBasis;
      fin_valid    <= 1'b0;
    end else begin
      if (take && last_byte) begin
        running_hash <= FnvOffsetBasis;
        fin_valid    <= 1'b1;
      end else begin
        if (take) begin
          running_hash <= hash_next;
        end
        if (fin_ready) begin
          fin_valid <= 1'b0;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take && last_byte) begin
      fin_hash <= hash_next;
    end
  end

endmodule

// ===== rtl/fss_signal_mod.sv =====
// Two-stage low-word modulo and centering, ending in the result register.
module fss_signal_mod (
  input  logic                    clk,
  input  logic                    rst,
  input  fss_pkg::fss_hash_word_t fin,
  output logic                    fin_ready,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [63:0]             hash_value,
  output logic signed [14:0]      signal_scaled
);
  import fss_pkg::*;

  // stage 1: reciprocal product
  logic        prod_valid;
  logic [63:0] prod_hash;
  logic [63:0] prod;
  logic        prod_ready;

  // stage 2 combinational: remainder and correction
  logic [QuotWidth-1:0] quot;
  logic [31:0]          quot_scaled;
  logic [31:0]          rem_wide;
  logic [15:0]          rem;
  logic [15:0]          rem_fix;
  logic signed [14:0]   signal_next;

  assign prod_ready = !result_valid || result_ready;
  assign fin_ready  = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (fin_ready) begin
        prod_valid <= fin.valid;
      end
      if (prod_ready) begin
        result_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin.valid) begin
      prod_hash <= fin.hash;
      prod      <= {32'd0, fin.hash[31:0]} * {32'd0, SigRecip};
    end
  end

  assign quot        = prod[63:SigShift];
  assign quot_scaled = 32'({{(32 - QuotWidth){1'b0}}, quot} * {17'd0, SigModulus});
  assign rem_wide    = prod_hash[31:0] - quot_scaled;
  assign rem         = rem_wide[15:0];
  assign rem_fix     = (rem >= {1'b0, SigModulus}) ? (rem - {1'b0, SigModulus}) : rem;
  assign signal_next = signed'(rem_fix[14:0] - SigCenter);

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      hash_value    <= prod_hash;
      signal_scaled <= signal_next;
    end
  end

endmodule

// ===== rtl/fnv1a_stream_signal.sv =====
// Top level: 64-bit FNV-1a over a byte stream with a scaled signal from the low word.
//
//   channel   direction  handshake                    payload
//   word      in         word_valid / word_ready      data_byte[7:0], last_byte
//   result    out        result_valid / result_ready  hash_value[63:0], signal_scaled[14:0]
//
// One word is taken per clock while word_ready is high; the loop through the running hash register
// (xor, then the shift-add prime multiply) is combinational back into that register.
// A word carrying last_byte yields one result by way of the hold stage, the reciprocal
// multiply stage and the remainder/correct into the result register.
// Reset clears the running hash to the offset basis and empties every stage.
// A stalled result backs up stage by stage; word_ready drops only when the
// finished-hash stage is full and cannot advance.
module fnv1a_stream_signal (
  input  logic               clk,
  input  logic               rst,
  input  logic               word_valid,
  output logic               word_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [63:0]        hash_value,
  output logic signed [14:0] signal_scaled
);
  import fss_pkg::*;

  fss_hash_word_t fin;     // finished hash, one per stream
  logic           fin_ready;

  // Hash loop: updates on every accepted word, restarts after the last one
  fss_hash_core u_hash (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .fin        (fin),
    .fin_ready  (fin_ready)
  );

  // Signal path: low32 mod 20001 by reciprocal multiply, then minus 10000
  fss_signal_mod u_sig (
    .clk           (clk),
    .rst           (rst),
    .fin           (fin),
    .fin_ready     (fin_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .hash_value    (hash_value),
    .signal_scaled (signal_scaled)
  );

endmodule

// ===== rtl/fss_checker.sv =====
// Port-level checks for the FNV-1a stream hash block, bound to the top level.
module fss_checker (
  input logic               clk,
  input logic               rst,
  input logic               word_valid,
  input logic               word_ready,
  input logic [7:0]         data_byte,
  input logic               last_byte,
  input logic               result_valid,
  input logic               result_ready,
  input logic [63:0]        hash_value,
  input logic signed [14:0] signal_scaled
);

  // a held result keeps its words
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(hash_value)
      && $stable(signal_scaled))
    else $error("result changed while stalled");

  // signal stays within +/-10000
  a_signal_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (signal_scaled >= -15'sd10000) && (signal_scaled <= 15'sd10000))
    else $error("signal_scaled out of range");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // a result must pass the hold, product and result registers after the last word; none right after a quiet start
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |=> !result_valid)
    else $error("result appeared before any stream could finish");

endmodule

bind fnv1a_stream_signal fss_checker u_fss_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the FNV-1a stream hash block with its scaled signal output.
module tb;
  import fss_pkg::*;

  // 64-bit FNV prime, 2^40 + 0x1B3
  localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01B3;

  // Margin to run on after every expected result has been matched.
  localparam int unsigned DrainCycles = 12;
  // Well above the slowest legal run: ~650 words, each with a random idle gap,
  // each result held by a random stall, plus the long hold-off.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 300;

  typedef struct packed {
    logic [63:0]        hash;
    logic signed [14:0] sig;
  } digest_t;

  // Tracks the running hash and queues the digest expected at each stream end.
  class digest_board;
    logic [63:0] running;
    digest_t     due_digests[$];
    int unsigned errors;

    function new();
      running = FnvOffsetBasis;
      errors  = 0;
    endfunction

    // Fold one accepted word into the hash; close the stream on last.
    function void absorb_word(logic [7:0] b, logic l);
      digest_t     d;
      logic [31:0] rem;
      int          s;
      running = (running ^ {56'd0, b}) * FnvPrime;
      if (l) begin
        rem    = running[31:0] % {17'd0, SigModulus};
        s      = int'(rem) - int'(SigCenter);
        d.hash = running;
        d.sig  = s[14:0];
        due_digests = {due_digests, d};
        running = FnvOffsetBasis;
      end
    endfunction

    function void match_digest(logic [63:0] h, logic signed [14:0] sg);
      digest_t d;
      if (due_digests.size() == 0) begin
        $error("result with nothing pending: hash_value %h signal_scaled %0d", h, sg);
        errors++;
        return;
      end
      d = due_digests.pop_front();
      if (h !== d.hash) begin
        $error("hash_value: expected %h, got %h", d.hash, h);
        errors++;
      end
      if (sg !== d.sig) begin
        $error("signal_scaled: expected %0d, got %0d", d.sig, sg);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_digests.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               word_valid;
  logic               word_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               result_valid;
  logic               result_ready;
  logic [63:0]        hash_value;
  logic signed [14:0] signal_scaled;

  digest_board board;
  int unsigned cycles;
  int unsigned words_sent;
  // Idling switches for each side, and the long hold-off request.
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_off_req;

  fnv1a_stream_signal dut (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hash_value   (hash_value),
    .signal_scaled(signal_scaled)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge; all inputs change by NBA only,
  // so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (word_valid && word_ready) board.absorb_word(data_byte, last_byte);
      if (result_valid && result_ready) board.match_digest(hash_value, signal_scaled);
    end
  end

  // Result side: random stall bursts when enabled, one long hold-off on request.
  initial begin
    result_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        result_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic l);
    word_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= l;
    @(posedge clk);
    while (!word_ready) @(posedge clk);
    words_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      word_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // One stream of random bytes; only the final word carries last.
  task automatic send_stream(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_word(8'($urandom), i == len);
  endtask

  // Mostly short streams, a few long ones.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 24);
    return $urandom_range(25, 64);
  endfunction

  task automatic random_streams(input int unsigned target, input bit idling);
    int unsigned stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      // idling comes and goes per stream, leaving quiet stretches
      tx_idle_on = idling && ($urandom_range(0, 3) != 0);
      rx_idle_on = idling && ($urandom_range(0, 3) != 0);
      send_stream(pick_len());
    end
  endtask

  initial begin
    board        = new();
    cycles       = 0;
    words_sent   = 0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_off_req = 1'b0;
    rst          = 1'b1;
    word_valid   = 1'b0;
    data_byte    = 8'h00;
    last_byte    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-byte streams right after reset and back to back,
    // byte extremes, alternating bit patterns, a longer run of zeros.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'hAA, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) send_word(8'h00, i == 5);
    for (int i = 0; i < 4; i++) send_word(8'hFF, i == 3);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b1);
    send_word(8'h7F, 1'b1);
    send_word(8'hFE, 1'b1);

    // Random with idling on both sides.
    random_streams(230, 1'b1);

    // Pressure: receiver holds off while short streams keep coming, so the
    // result path backs up and word_ready must drop.
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_stream($urandom_range(1, 3));

    random_streams(160, 1'b1);

    // Final stretch at full rate, no idling.
    random_streams(120, 1'b0);
    word_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== fnv1a_stream_signal.f =====
rtl/fss_pkg.sv
rtl/fss_hash_core.sv
rtl/fss_signal_mod.sv
rtl/fnv1a_stream_signal.sv
rtl/fss_checker.sv
bench/tb.sv
